FILE: sv/lbvm_pkg.sv
`timescale 1ns / 1ps
package lbvm_pkg;
   localparam int MAX_EMPTY_DEF = 63;
   localparam int STEP_Q_DEF    = 80;
   localparam int CORDIC_N      = 15;

   localparam logic [2:0] CSR_MAX_RANGE = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_X  = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Y  = 3'd2;
   localparam logic [2:0] CSR_ORIGIN_Z  = 3'd3;
   localparam logic [2:0] CSR_HEAD_H    = 3'd4;
   localparam logic [2:0] CSR_HEAD_A    = 3'd5;

   localparam logic [1:0] OCC_EMPTY    = 2'd0;
   localparam logic [1:0] OCC_OCCUPIED = 2'd1;
   localparam logic [1:0] OCC_POSSIBLE = 2'd2;

   typedef enum logic [1:0] {
      KIND_MISS = 2'd0,
      KIND_NEAR = 2'd1,
      KIND_HIT  = 2'd2
   } kind_type;

   // Classified return handed from the front to the back.
   typedef struct packed {
      kind_type           kind;
      logic signed [19:0] range;
      logic [19:0]        max_range;
      logic [15:0]        ang_h;
      logic [15:0]        ang_a;
   } job_type;

   function automatic logic [14:0] atan_entry(input logic [3:0] i);
      case (i)
         4'd0:    atan_entry = 15'd8192;
         4'd1:    atan_entry = 15'd4836;
         4'd2:    atan_entry = 15'd2555;
         4'd3:    atan_entry = 15'd1297;
         4'd4:    atan_entry = 15'd651;
         4'd5:    atan_entry = 15'd326;
         4'd6:    atan_entry = 15'd163;
         4'd7:    atan_entry = 15'd81;
         4'd8:    atan_entry = 15'd41;
         4'd9:    atan_entry = 15'd20;
         4'd10:   atan_entry = 15'd10;
         4'd11:   atan_entry = 15'd5;
         4'd12:   atan_entry = 15'd3;
         4'd13:   atan_entry = 15'd1;
         4'd14:   atan_entry = 15'd1;
         default: atan_entry = 15'd0;
      endcase
   endfunction
endpackage

FILE: sv/lbvm_front.sv
`timescale 1ns / 1ps
// Adds the heading to the beam angles and classifies the return.
module lbvm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [19:0]    req_range_q,
   input  logic [15:0]           req_beam_horizontal,
   input  logic [15:0]           req_beam_altitude,
   input  logic [19:0]           max_range,
   input  logic [15:0]           heading_horizontal,
   input  logic [15:0]           heading_altitude,
   output logic                  job_valid,
   input  logic                  job_stall,
   output lbvm_pkg::job_type     job
);
   lbvm_pkg::job_type job_ff, job_in;
   logic valid_ff;
   logic signed [22:0] two_r;
   logic signed [22:0] three_m;

   assign req_stall = valid_ff && job_stall;
   assign job_valid = valid_ff;
   assign job = job_ff;

   always_comb begin
      two_r   = 23'(req_range_q) <<< 1;
      three_m = 23'({1'b0, max_range}) + (23'({1'b0, max_range}) <<< 1);
      job_in.range     = req_range_q;
      job_in.max_range = max_range;
      job_in.ang_h     = req_beam_horizontal + heading_horizontal;
      job_in.ang_a     = req_beam_altitude + heading_altitude;
      if (two_r >= three_m) begin
         job_in.kind = lbvm_pkg::KIND_MISS;
      end else if (req_range_q <= 0) begin
         job_in.kind = lbvm_pkg::KIND_NEAR;
      end else begin
         job_in.kind = lbvm_pkg::KIND_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         valid_ff <= 1'b1;
      end else if (!job_stall) begin
         valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         job_ff <= job_in;
      end
   end
endmodule

FILE: sv/lbvm_queue.sv
`timescale 1ns / 1ps
// Two-entry queue between front and back.
module lbvm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  lbvm_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_stall,
   output lbvm_pkg::job_type out_job
);
   lbvm_pkg::job_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_job;
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !pop) else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("queue count lost a push");
endmodule

FILE: sv/lbvm_back.sv
`timescale 1ns / 1ps
// Computes the direction with two CORDIC rotations run side by side, then marches the points.
module lbvm_back #(
   parameter int MAX_EMPTY = lbvm_pkg::MAX_EMPTY_DEF,
   parameter int STEP_Q    = lbvm_pkg::STEP_Q_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_stall,
   input  lbvm_pkg::job_type  job,
   input  logic signed [23:0] origin_x,
   input  logic signed [23:0] origin_y,
   input  logic signed [23:0] origin_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [24:0] rsp_point_x,
   output logic signed [24:0] rsp_point_y,
   output logic signed [24:0] rsp_point_z,
   output logic [1:0]         rsp_occupancy,
   output logic               rsp_last
);
   localparam int CW = $clog2(MAX_EMPTY + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_ROT, S_DIR, S_MULT, S_ADD, S_OUT
   } state_type;

   state_type state_ff;
   lbvm_pkg::job_type job_ff;
   logic signed [17:0] xh_ff, yh_ff, xa_ff, ya_ff;
   logic signed [16:0] ah_ff, aa_ff;
   logic neg_h_ff, neg_a_ff;
   logic [3:0] it_ff;
   logic signed [16:0] dx_ff, dy_ff, dz_ff, ch_ff, sh_ff, ca_ff;
   logic [1:0] dstep_ff;
   logic signed [20:0] t_ff;
   logic [CW-1:0] n_ff;
   logic [1:0] occ_ff;
   logic lst_ff;
   logic signed [38:0] px_ff, py_ff, pz_ff;
   logic signed [24:0] ox_ff, oy_ff, oz_ff;
   logic [1:0] oocc_ff;
   logic olast_ff;
   logic ovalid_ff;

   logic signed [16:0] fa_h, fa_a;
   logic fn_h, fn_a;
   logic signed [17:0] xh_in, yh_in, xa_in, ya_in;
   logic signed [16:0] ah_in, aa_in;
   logic signed [16:0] c_ch, c_sh, c_ca, c_sa;
   logic signed [33:0] prod;
   logic signed [16:0] rnd_prod;
   logic signed [22:0] lim2;
   logic empty_more;

   function automatic logic signed [16:0] fold(input logic [15:0] a, output logic neg);
      logic signed [16:0] s;
      s = 17'(signed'(a));
      neg = 1'b0;
      if (s > 17'sd16384) begin
         s = s - 17'sd32768; neg = 1'b1;
      end else if (s < -17'sd16384) begin
         s = s + 17'sd32768; neg = 1'b1;
      end
      return s;
   endfunction

   function automatic logic signed [16:0] clamp(input logic signed [17:0] v, input logic neg);
      logic signed [17:0] w;
      w = neg ? -v : v;
      if (w > 18'sd32767) return 17'sd32767;
      if (w < -18'sd32767) return -17'sd32767;
      return 17'(w);
   endfunction

   always_comb begin
      fa_h = fold(job.ang_h, fn_h);
      fa_a = fold(job.ang_a, fn_a);
      if (ah_ff >= 0) begin
         xh_in = xh_ff - (yh_ff >>> it_ff);
         yh_in = yh_ff + (xh_ff >>> it_ff);
         ah_in = ah_ff - 17'(lbvm_pkg::atan_entry(it_ff));
      end else begin
         xh_in = xh_ff + (yh_ff >>> it_ff);
         yh_in = yh_ff - (xh_ff >>> it_ff);
         ah_in = ah_ff + 17'(lbvm_pkg::atan_entry(it_ff));
      end
      if (aa_ff >= 0) begin
         xa_in = xa_ff - (ya_ff >>> it_ff);
         ya_in = ya_ff + (xa_ff >>> it_ff);
         aa_in = aa_ff - 17'(lbvm_pkg::atan_entry(it_ff));
      end else begin
         xa_in = xa_ff + (ya_ff >>> it_ff);
         ya_in = ya_ff - (xa_ff >>> it_ff);
         aa_in = aa_ff + 17'(lbvm_pkg::atan_entry(it_ff));
      end
      c_ch = clamp(xh_ff, neg_h_ff);
      c_sh = clamp(yh_ff, neg_h_ff);
      c_ca = clamp(xa_ff, neg_a_ff);
      c_sa = clamp(ya_ff, neg_a_ff);
      // Step one forms the x product from the cosine, step two the y product from the sine.
      prod = ca_ff * (dstep_ff[1] ? sh_ff : ch_ff);
      rnd_prod = 17'((prod + 34'sd16384) >>> 15);
      lim2 = (23'(job_ff.range) <<< 1) - 23'(STEP_Q);
      empty_more = (n_ff < CW'(MAX_EMPTY)) &&
                   ((23'(t_ff) <<< 1) < lim2);
   end

   assign job_stall = (state_ff != S_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_point_x = ox_ff;
   assign rsp_point_y = oy_ff;
   assign rsp_point_z = oz_ff;
   assign rsp_occupancy = oocc_ff;
   assign rsp_last = olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         if (ovalid_ff && !rsp_stall && state_ff != S_ADD) ovalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff <= job;
                  xh_ff <= 18'sd19898; yh_ff <= '0; ah_ff <= fa_h; neg_h_ff <= fn_h;
                  xa_ff <= 18'sd19898; ya_ff <= '0; aa_ff <= fa_a; neg_a_ff <= fn_a;
                  it_ff <= '0;
                  state_ff <= S_ROT;
               end
            end
            S_ROT: begin
               xh_ff <= xh_in; yh_ff <= yh_in; ah_ff <= ah_in;
               xa_ff <= xa_in; ya_ff <= ya_in; aa_ff <= aa_in;
               it_ff <= it_ff + 4'd1;
               if (it_ff == 4'(lbvm_pkg::CORDIC_N - 1)) begin
                  state_ff <= S_DIR;
                  dstep_ff <= 2'd0;
               end
            end
            S_DIR: begin
               // Two products share one multiplier.
               ch_ff <= c_ch; sh_ff <= c_sh; ca_ff <= c_ca; dz_ff <= c_sa;
               if (dstep_ff == 2'd0) begin
                  dstep_ff <= 2'd1;
               end else if (dstep_ff == 2'd1) begin
                  dx_ff <= rnd_prod; dstep_ff <= 2'd2;
               end else begin
                  dy_ff <= rnd_prod;
                  n_ff <= '0;
                  case (job_ff.kind)
                     lbvm_pkg::KIND_MISS: begin
                        t_ff <= 21'(job_ff.max_range); occ_ff <= lbvm_pkg::OCC_POSSIBLE;
                        lst_ff <= 1'b1;
                     end
                     lbvm_pkg::KIND_NEAR: begin
                        t_ff <= 21'(STEP_Q); occ_ff <= lbvm_pkg::OCC_OCCUPIED;
                        lst_ff <= 1'b1;
                     end
                     default: begin
                        t_ff <= 21'(STEP_Q); occ_ff <= lbvm_pkg::OCC_EMPTY;
                        lst_ff <= 1'b0;
                     end
                  endcase
                  state_ff <= S_MULT;
               end
            end
            S_MULT: begin
               if (job_ff.kind == lbvm_pkg::KIND_HIT && !lst_ff && !empty_more) begin
                  t_ff <= 21'(job_ff.range);
                  occ_ff <= lbvm_pkg::OCC_OCCUPIED;
                  lst_ff <= 1'b1;
               end else begin
                  px_ff <= dx_ff * 22'(t_ff);
                  py_ff <= dy_ff * 22'(t_ff);
                  pz_ff <= dz_ff * 22'(t_ff);
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               if (!ovalid_ff || !rsp_stall) begin
                  ox_ff <= 25'(origin_x) + 25'((px_ff + 39'sd16384) >>> 15);
                  oy_ff <= 25'(origin_y) + 25'((py_ff + 39'sd16384) >>> 15);
                  oz_ff <= 25'(origin_z) + 25'((pz_ff + 39'sd16384) >>> 15);
                  oocc_ff <= occ_ff;
                  olast_ff <= lst_ff;
                  ovalid_ff <= 1'b1;
                  if (lst_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     n_ff <= n_ff + CW'(1);
                     t_ff <= t_ff + 21'(STEP_Q);
                     state_ff <= S_MULT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT) |-> (it_ff < 4'(lbvm_pkg::CORDIC_N))) else $error("cordic overrun");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_occupancy != lbvm_pkg::OCC_EMPTY))
      else $error("last point marked empty");
endmodule

FILE: sv/lidar_beam_voxel_marcher.sv
`timescale 1ns / 1ps
// Lidar beam voxel marcher.
// The req_ channel carries one lidar return per transaction: a signed range
// in 1/16 cm and two beam angles. The rsp_ channel carries the sample points
// along that beam, one per transaction, with rsp_last marking the final one.
// A transaction completes on a rising edge where valid is high and stall low.
// The csr_ port writes max_range, origin and heading registers; write it only
// while the block is idle.
// A front stage adds the heading and classifies the return (miss, near or
// hit); a two-entry queue holds classified returns; the back stage runs two
// CORDIC rotations side by side, forms the direction, then emits the points
// one at a time (multiply then add), up to MAX_EMPTY + 1 points, and takes
// the next return only once it has issued the last point of a beam.
// Synchronous reset empties the queue and returns the back stage to idle;
// configuration registers reset to zero.
// If the receiver stalls, the current point is held and the march pauses.
module lidar_beam_voxel_marcher #(
   parameter int MAX_EMPTY = lbvm_pkg::MAX_EMPTY_DEF,
   parameter int STEP_Q    = lbvm_pkg::STEP_Q_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [19:0] req_range_q,
   input  logic [15:0]        req_beam_horizontal,
   input  logic [15:0]        req_beam_altitude,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [24:0] rsp_point_x,
   output logic signed [24:0] rsp_point_y,
   output logic signed [24:0] rsp_point_z,
   output logic [1:0]         rsp_occupancy,
   output logic               rsp_last,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data
);
   logic [19:0] max_range_ff;
   logic signed [23:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [15:0] head_h_ff, head_a_ff;
   logic f_valid, f_stall, q_valid, q_stall;
   lbvm_pkg::job_type f_job, q_job;

   // Register writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= '0;
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         origin_z_ff  <= '0;
         head_h_ff    <= '0;
         head_a_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lbvm_pkg::CSR_MAX_RANGE: max_range_ff <= csr_data[19:0];
            lbvm_pkg::CSR_ORIGIN_X:  origin_x_ff  <= csr_data;
            lbvm_pkg::CSR_ORIGIN_Y:  origin_y_ff  <= csr_data;
            lbvm_pkg::CSR_ORIGIN_Z:  origin_z_ff  <= csr_data;
            lbvm_pkg::CSR_HEAD_H:    head_h_ff    <= csr_data[15:0];
            lbvm_pkg::CSR_HEAD_A:    head_a_ff    <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   lbvm_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_range_q,
      .req_beam_horizontal, .req_beam_altitude,
      .max_range(max_range_ff), .heading_horizontal(head_h_ff),
      .heading_altitude(head_a_ff),
      .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
   );

   lbvm_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_job(f_job),
      .out_valid(q_valid), .out_stall(q_stall), .out_job(q_job)
   );

   lbvm_back #(.MAX_EMPTY(MAX_EMPTY), .STEP_Q(STEP_Q)) u_back (
      .clock, .reset, .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
      .origin_x(origin_x_ff), .origin_y(origin_y_ff), .origin_z(origin_z_ff),
      .rsp_valid, .rsp_stall, .rsp_point_x, .rsp_point_y, .rsp_point_z,
      .rsp_occupancy, .rsp_last
   );
endmodule

FILE: bench/lbvm_checker.sv
`timescale 1ns / 1ps
module lbvm_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [19:0] req_range_q,
   input  logic [15:0]        req_beam_horizontal,
   input  logic [15:0]        req_beam_altitude,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [24:0] rsp_point_x,
   input  logic signed [24:0] rsp_point_y,
   input  logic signed [24:0] rsp_point_z,
   input  logic [1:0]         rsp_occupancy,
   input  logic               rsp_last,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data,
   output int                 fail_count,
   output int                 points_pending
);
   typedef struct {
      logic [24:0] x, y, z;
      logic [1:0]  occ;
      logic        last;
   } point_type;

   point_type point_queue[$];

   logic [19:0]        max_range_r;
   logic signed [23:0] org_x, org_y, org_z;
   logic [15:0]        head_h, head_a;

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_q15(longint p);
      return (p + 16384) >>> 15;
   endfunction

   function automatic longint sat15(longint v);
      if (v > 32767) return 32767;
      if (v < -32767) return -32767;
      return v;
   endfunction

   // Gain-compensated CORDIC over a folded binary angle.
   task automatic beam_sincos(input logic [15:0] ang, output longint s,
                              output longint c);
      longint a, x, y, nx, atn;
      bit flip;
      a = ang;
      x = 19898;
      y = 0;
      flip = 0;
      if (a >= 32768) a -= 65536;
      if (a > 16384) begin
         a -= 32768;
         flip = 1;
      end else if (a < -16384) begin
         a += 32768;
         flip = 1;
      end
      for (int i = 0; i < lbvm_pkg::CORDIC_N; i++) begin
         atn = lbvm_pkg::atan_entry(4'(i));
         if (a >= 0) begin
            nx = x - shr_floor(y, i);
            y  = y + shr_floor(x, i);
            a -= atn;
         end else begin
            nx = x + shr_floor(y, i);
            y  = y - shr_floor(x, i);
            a += atn;
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = sat15(x);
      s = sat15(y);
   endtask

   task automatic push_point(input longint dx, dy, dz, t, input logic [1:0] occ,
                             input logic last);
      point_type p;
      p.x = 25'(longint'(org_x) + round_q15(dx * t));
      p.y = 25'(longint'(org_y) + round_q15(dy * t));
      p.z = 25'(longint'(org_z) + round_q15(dz * t));
      p.occ = occ;
      p.last = last;
      point_queue.push_back(p);
   endtask

   task automatic march_beam(input logic signed [19:0] rq, input logic [15:0] bh,
                             input logic [15:0] ba);
      longint sh, ch, sa, ca, dx, dy, dz, t, rng;
      int n;
      beam_sincos(16'(bh + head_h), sh, ch);
      beam_sincos(16'(ba + head_a), sa, ca);
      dx = round_q15(ca * ch);
      dy = round_q15(ca * sh);
      dz = sa;
      rng = rq;
      if (2 * rng >= 3 * longint'(max_range_r)) begin
         push_point(dx, dy, dz, max_range_r, lbvm_pkg::OCC_POSSIBLE, 1'b1);
      end else if (rng <= 0) begin
         push_point(dx, dy, dz, lbvm_pkg::STEP_Q_DEF, lbvm_pkg::OCC_OCCUPIED, 1'b1);
      end else begin
         n = 0;
         t = lbvm_pkg::STEP_Q_DEF;
         while (n < lbvm_pkg::MAX_EMPTY_DEF && 2 * t < 2 * rng - lbvm_pkg::STEP_Q_DEF) begin
            push_point(dx, dy, dz, t, lbvm_pkg::OCC_EMPTY, 1'b0);
            n++;
            t += lbvm_pkg::STEP_Q_DEF;
         end
         push_point(dx, dy, dz, rng, lbvm_pkg::OCC_OCCUPIED, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      point_type e;
      if (reset) begin
         max_range_r <= '0;
         org_x <= '0;
         org_y <= '0;
         org_z <= '0;
         head_h <= '0;
         head_a <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               lbvm_pkg::CSR_MAX_RANGE: max_range_r <= csr_data[19:0];
               lbvm_pkg::CSR_ORIGIN_X:  org_x <= csr_data;
               lbvm_pkg::CSR_ORIGIN_Y:  org_y <= csr_data;
               lbvm_pkg::CSR_ORIGIN_Z:  org_z <= csr_data;
               lbvm_pkg::CSR_HEAD_H:    head_h <= csr_data[15:0];
               lbvm_pkg::CSR_HEAD_A:    head_a <= csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            march_beam(req_range_q, req_beam_horizontal, req_beam_altitude);
         if (rsp_valid && !rsp_stall) begin
            if (point_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected point x=%0d y=%0d z=%0d occ=%0d last=%0d",
                           rsp_point_x, rsp_point_y, rsp_point_z, rsp_occupancy,
                           rsp_last);
            end else begin
               e = point_queue.pop_front();
               if (e.x !== rsp_point_x || e.y !== rsp_point_y || e.z !== rsp_point_z
                   || e.occ !== rsp_occupancy || e.last !== rsp_last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"point mismatch: exp %0d %0d %0d occ %0d last %0d,",
                               " got %0d %0d %0d occ %0d last %0d"},
                              $signed(e.x), $signed(e.y), $signed(e.z), e.occ, e.last,
                              rsp_point_x, rsp_point_y, rsp_point_z, rsp_occupancy,
                              rsp_last);
               end
            end
         end
      end
      points_pending = point_queue.size();
   end

   initial begin
      fail_count = 0;
      points_pending = 0;
   end
endmodule

FILE: bench/tb_lidar_beam_voxel_marcher.sv
`timescale 1ns / 1ps
module tb_lidar_beam_voxel_marcher;
   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [19:0] req_range_q = '0;
   logic [15:0]        req_beam_horizontal = '0;
   logic [15:0]        req_beam_altitude = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [24:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic [1:0]         rsp_occupancy;
   logic               rsp_last;
   logic               csr_write = 0;
   logic [2:0]         csr_index = '0;
   logic [23:0]        csr_data = '0;
   int                 fail_count, points_pending;
   int                 quiet_cycles = 0;
   bit                 hold_long = 0;   // set by the stimulus to force a long receiver hold-off

   localparam int QUIET_LIMIT = 20000;
   // An index past the end of the register list.
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   lidar_beam_voxel_marcher u_dut (.*);

   lbvm_checker u_chk (.*);

   // Watchdog: a stretch with no transaction on either channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_lidar_beam_voxel_marcher: errors");
         $finish;
      end
   end

   // Mostly short gaps, occasionally long ones, with stretches of none.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Receiver: random stall, plus one long hold-off on request.
   initial begin : receiver
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            rsp_stall <= 0;
            hold_long = 0;
         end else begin
            n = gap_length();
            if (n > 0) begin
               rsp_stall <= 1;
               repeat (n - 1) @(posedge clock);
               @(posedge clock);
               rsp_stall <= 0;
            end
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 0;
   endtask

   // Drop the request, drain all expected points, then let the back stage settle.
   task automatic wait_idle();
      req_valid <= 0;
      while (points_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // Leaves valid high after the transaction; a gap or wait_idle drops it.
   task automatic send_return(input logic signed [19:0] r, input logic [15:0] h,
                              input logic [15:0] a, input bit gaps);
      int n;
      if (gaps) begin
         n = gap_length();
         if (n > 0) begin
            req_valid <= 0;
            repeat (n) @(posedge clock);
         end
      end
      req_valid <= 1;
      req_range_q <= r;
      req_beam_horizontal <= h;
      req_beam_altitude <= a;
      do @(posedge clock); while (req_stall);
   endtask

   // Ranges are mostly short so that marches stay brief; some span the cap.
   function automatic logic signed [19:0] random_range(input int mr);
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 20'($urandom_range(1, 1200));
      if (r < 65) return 20'($urandom_range(4000, 6000));
      if (r < 75) return 20'(-int'($urandom_range(0, 524288)));
      if (r < 85) return 20'($urandom_range(mr, mr * 2));
      return 20'($urandom);
   endfunction

   initial begin : stimulus
      logic [15:0] angles[6];
      int mr;
      angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
      repeat (3) @(posedge clock);
      reset <= 0;

      // Default registers: max_range 0 so every range of zero or more is a miss.
      send_return(20'sd0, 16'h0000, 16'h0000, 0);
      send_return(20'sd100, 16'hFFFF, 16'hFFFF, 0);
      send_return(-20'sd524288, 16'h0000, 16'h0000, 0);
      wait_idle();

      write_reg(lbvm_pkg::CSR_MAX_RANGE, 24'd16000);
      write_reg(lbvm_pkg::CSR_ORIGIN_X, 24'h7FFFFF);
      write_reg(lbvm_pkg::CSR_ORIGIN_Y, 24'h800000);
      write_reg(lbvm_pkg::CSR_ORIGIN_Z, 24'd1234);
      write_reg(lbvm_pkg::CSR_HEAD_H, 24'h00FFFF);
      write_reg(lbvm_pkg::CSR_HEAD_A, 24'h008000);
      write_reg(CSR_UNUSED, 24'hABCDEF);   // undefined index, ignored
      for (int i = 0; i < 6; i++)
         send_return(20'(i * 17 + 1), angles[i], angles[5 - i], 0);
      send_return(20'sd0, 16'h1234, 16'h4321, 0);        // near return
      send_return(-20'sd1, 16'h0000, 16'h0000, 0);
      send_return(20'sd23999, 16'h0000, 16'h0000, 0);    // just short of a miss
      send_return(20'sd24000, 16'h0000, 16'h0000, 0);    // miss boundary
      send_return(20'sd524287, 16'hFFFF, 16'hFFFF, 0);
      send_return(20'sd120, 16'h0000, 16'h0000, 0);      // no empty point
      send_return(20'sd121, 16'h0000, 16'h0000, 0);      // one empty point
      send_return(20'sd10000, 16'h2000, 16'h2000, 0);    // empty cap reached
      wait_idle();

      write_reg(lbvm_pkg::CSR_MAX_RANGE, 24'hFFFFF);
      write_reg(lbvm_pkg::CSR_HEAD_H, 24'h000000);
      write_reg(lbvm_pkg::CSR_HEAD_A, 24'h000000);
      write_reg(lbvm_pkg::CSR_ORIGIN_X, 24'h000000);
      send_return(20'sd524287, 16'h0000, 16'h0000, 0);
      send_return(20'sd6000, 16'h0000, 16'h0000, 0);
      // Long hold-off while returns keep coming so the block backs up.
      hold_long = 1;
      for (int i = 0; i < 5; i++)
         send_return(20'sd3000, 16'($urandom), 16'($urandom), 0);
      wait_idle();

      // Random phases with fresh settings.
      for (int ph = 0; ph < 5; ph++) begin
         mr = (ph == 0) ? 0 : $urandom_range(100, 20000);
         write_reg(lbvm_pkg::CSR_MAX_RANGE, 24'(mr));
         write_reg(lbvm_pkg::CSR_ORIGIN_X, 24'($urandom));
         write_reg(lbvm_pkg::CSR_ORIGIN_Y, 24'($urandom));
         write_reg(lbvm_pkg::CSR_ORIGIN_Z, 24'($urandom));
         write_reg(lbvm_pkg::CSR_HEAD_H, 24'($urandom));
         write_reg(lbvm_pkg::CSR_HEAD_A, 24'($urandom));
         for (int i = 0; i < 25; i++)
            send_return(random_range(mr), 16'($urandom), 16'($urandom), 1);
         wait_idle();
      end

      if (fail_count == 0)
         $display("tb_lidar_beam_voxel_marcher: clean");
      else
         $display("tb_lidar_beam_voxel_marcher: errors");
      $finish;
   end
endmodule
